// ----- rtl/oqrk_pkg.sv -----
package oqrk_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int CMD_W = 2;
   localparam int KEY_W = 31;
   localparam int PAY_W = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W = 4;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOKEY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ENTRY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } record_type;

endpackage

// ----- rtl/oqrk_store.sv -----
module oqrk_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [oqrk_pkg::IDX_W-1:0] wr_addr,
   input  oqrk_pkg::record_type       wr_rec,
   input  logic [oqrk_pkg::IDX_W-1:0] rd_addr,
   output oqrk_pkg::record_type       rd_rec
);
   import oqrk_pkg::*;

   record_type records_ff [DEPTH];
   record_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         records_ff[wr_addr] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= records_ff[rd_addr];
   end

   assign rd_rec = rd_ff;

endmodule

// ----- rtl/ordered_queue_remove_by_key.sv -----
// Remove: one stored record compared or moved per cycle by the shared key
// comparator and the record store, which has one write and one read port.
// Dump: one record word per cycle while the result side is ready. One
// command is in work at a time; a new one is taken after the last result
// word is registered. Reset empties the list at once; the record store
// itself is not cleared.
module ordered_queue_remove_by_key (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [oqrk_pkg::CMD_W-1:0]    req_command,
   input  logic [oqrk_pkg::KEY_W-1:0]    req_key,
   input  logic [oqrk_pkg::PAY_W-1:0]    req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [oqrk_pkg::STATUS_W-1:0] rsp_status,
   output logic [oqrk_pkg::KEY_W-1:0]    rsp_entry_key,
   output logic [oqrk_pkg::PAY_W-1:0]    rsp_entry_payload,
   output logic [oqrk_pkg::POS_W-1:0]    rsp_position,
   output logic                          rsp_last
);
   import oqrk_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_DUMP = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [PAY_W-1:0]    rsp_payload_ff;
   logic [POS_W-1:0]    rsp_position_ff;
   logic                rsp_last_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   record_type          wr_rec;
   logic [IDX_W-1:0]    rd_addr;
   record_type          rd_rec;

   logic                out_free;
   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic [KEY_W-1:0]    emit_key;
   logic [PAY_W-1:0]    emit_payload;
   logic [POS_W-1:0]    emit_position;
   logic                emit_last;

   logic [IDX_W-1:0]    idx_next;
   logic [IDX_W-1:0]    idx_next2;
   logic [CNT_W-1:0]    idx_inc_cnt;
   logic                key_hit;

   oqrk_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_rec  (wr_rec),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign idx_next = idx_ff + 1'b1;
   assign idx_next2 = idx_ff + IDX_W'(2);
   assign idx_inc_cnt = CNT_W'(idx_ff) + 1'b1;
   // shared comparator: stored key against the key being removed
   assign key_hit = (rd_rec.key == key_ff);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      key_in = key_ff;
      status_in = status_ff;
      rd_addr = idx_ff;
      wr_en = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_rec = '{key: req_key, payload: req_payload};
      emit = 1'b0;
      emit_status = ST_DONE;
      emit_key = '0;
      emit_payload = '0;
      emit_position = '0;
      emit_last = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_valid) begin
               idx_in = '0;
               state_in = S_FINISH;
               unique case (req_command)
                  CMD_APPEND: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                        status_in = ST_DONE;
                     end
                  end
                  CMD_REMOVE: begin
                     key_in = req_key;
                     if (count_ff == '0) begin
                        status_in = ST_NOKEY;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (key_hit) begin
               // fetch the record behind the hole
               rd_addr = idx_next;
               state_in = S_SHIFT;
            end else if (idx_inc_cnt == count_ff) begin
               status_in = ST_NOKEY;
               state_in = S_FINISH;
            end else begin
               idx_in = idx_next;
               rd_addr = idx_next;
            end
         end
         S_SHIFT: begin
            if (idx_inc_cnt < count_ff) begin
               wr_en = 1'b1;
               wr_addr = idx_ff;
               wr_rec = rd_rec;
               idx_in = idx_next;
               rd_addr = idx_next2;
            end else begin
               count_in = count_ff - 1'b1;
               status_in = ST_DONE;
               state_in = S_FINISH;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               emit = 1'b1;
               emit_status = ST_ENTRY;
               emit_key = rd_rec.key;
               emit_payload = rd_rec.payload;
               emit_position = POS_W'(idx_ff);
               emit_last = (idx_inc_cnt == count_ff);
               if (idx_inc_cnt == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_next;
                  rd_addr = idx_next;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               emit = 1'b1;
               emit_status = status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      status_ff <= status_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_key_ff <= emit_key;
         rsp_payload_ff <= emit_payload;
         rsp_position_ff <= emit_position;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_key = rsp_key_ff;
   assign rsp_entry_payload = rsp_payload_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("record count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1) ||
      (count_ff + 1 == $past(count_ff)))
      else $error("record count moved by more than one");

   a_idx_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_SHIFT || state_ff == S_DUMP) |->
      (CNT_W'(idx_ff) < count_ff))
      else $error("walk index outside the list");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted word left sequencer idle");
`endif

endmodule

// ----- test/tb_ordered_queue_remove_by_key.sv -----
`timescale 1ns / 100ps

module tb_ordered_queue_remove_by_key;
   import oqrk_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
   localparam logic [PAY_W-1:0] PAY_MAX = {PAY_W{1'b1}};

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    entry_key;
      logic [PAY_W-1:0]    entry_payload;
      logic [POS_W-1:0]    position;
      logic                last;
   } rsp_word_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic [KEY_W-1:0]    req_key;
   logic [PAY_W-1:0]    req_payload;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [KEY_W-1:0]    rsp_entry_key;
   logic [PAY_W-1:0]    rsp_entry_payload;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_last;

   // shadow copy of the record list
   logic [KEY_W-1:0] list_keys [DEPTH];
   logic [PAY_W-1:0] list_payloads [DEPTH];
   int               list_count;

   rsp_word_type expected_words [$];
   int           mismatch_count;
   bit           quiet_mode;

   ordered_queue_remove_by_key uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_payload (rsp_entry_payload),
      .rsp_position      (rsp_position),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

   function automatic int draw_gap();
      if (quiet_mode)
         return 0;
      return $urandom_range(0, 5);
   endfunction

   function automatic void push_word(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] k,
                                     logic [PAY_W-1:0] p, logic [POS_W-1:0] pos, logic last);
      rsp_word_type w;
      w.status = status;
      w.entry_key = k;
      w.entry_payload = p;
      w.position = pos;
      w.last = last;
      expected_words.push_back(w);
   endfunction

   function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                           logic [PAY_W-1:0] p);
      int hit;
      hit = -1;
      case (cmd)
         CMD_APPEND: begin
            if (list_count >= DEPTH) begin
               push_word(ST_FULL, '0, '0, '0, 1'b1);
            end else begin
               list_keys[list_count] = k;
               list_payloads[list_count] = p;
               list_count++;
               push_word(ST_DONE, '0, '0, '0, 1'b1);
            end
         end
         CMD_REMOVE: begin
            for (int i = 0; i < list_count; i++) begin
               if (hit < 0 && list_keys[i] == k)
                  hit = i;
            end
            if (hit < 0) begin
               push_word(ST_NOKEY, '0, '0, '0, 1'b1);
            end else begin
               // close the gap, keep order
               for (int i = hit; i + 1 < list_count; i++) begin
                  list_keys[i] = list_keys[i + 1];
                  list_payloads[i] = list_payloads[i + 1];
               end
               list_count--;
               push_word(ST_DONE, '0, '0, '0, 1'b1);
            end
         end
         CMD_DUMP: begin
            if (list_count == 0)
               push_word(ST_EMPTY, '0, '0, '0, 1'b1);
            for (int i = 0; i < list_count; i++)
               push_word(ST_ENTRY, list_keys[i], list_payloads[i], i[POS_W-1:0],
                         (i + 1 == list_count));
         end
         default: begin
            push_word(ST_DONE, '0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   // valid stays high from one word to the next when no gap is drawn
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                            input logic [PAY_W-1:0] p);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= k;
      req_payload <= p;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_command(cmd, k, p);
   endtask

   // result side: stall a random number of cycles before each word
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1 || reset !== 1'b0) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: st=%0d key=%h pay=%h pos=%0d last=%0d",
                        rsp_status, rsp_entry_key, rsp_entry_payload, rsp_position,
                        rsp_last);
         end else begin
            want = expected_words.pop_front();
            if (rsp_status !== want.status || rsp_entry_key !== want.entry_key ||
                rsp_entry_payload !== want.entry_payload ||
                rsp_position !== want.position || rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp st=%0d key=%h pay=%h pos=%0d last=%0d",
                           want.status, want.entry_key, want.entry_payload,
                           want.position, want.last);
                  $display("          got st=%0d key=%h pay=%h pos=%0d last=%0d",
                           rsp_status, rsp_entry_key, rsp_entry_payload,
                           rsp_position, rsp_last);
               end
            end
         end
      end
   end

   task automatic test_empty_list();
      send_word(CMD_DUMP, '0, '0);
      send_word(CMD_REMOVE, KEY_MAX, PAY_MAX);
      send_word(CMD_UNUSED, KEY_MAX, PAY_MAX);
   endtask

   task automatic test_fill_and_full();
      send_word(CMD_APPEND, '0, '0);
      send_word(CMD_APPEND, KEY_MAX, PAY_MAX);
      send_word(CMD_APPEND, 31'h2AAA_AAAA, 32'h5555_5555);
      send_word(CMD_APPEND, 31'h5555_5555, 32'hAAAA_AAAA);
      // duplicate keys, distinct payloads
      send_word(CMD_APPEND, 31'h0000_1234, 32'h0000_0001);
      send_word(CMD_APPEND, 31'h0000_1234, 32'h0000_0002);
      for (int i = 6; i < DEPTH; i++)
         send_word(CMD_APPEND, KEY_W'($urandom()), $urandom());
      send_word(CMD_APPEND, 31'h7777_7777, 32'hDEAD_BEEF);
      send_word(CMD_DUMP, '0, '0);
   endtask

   task automatic test_remove_cases();
      logic [KEY_W-1:0] tail_key;
      tail_key = list_keys[list_count - 1];
      send_word(CMD_REMOVE, 31'h0000_1234, '0);
      send_word(CMD_REMOVE, tail_key, '0);
      send_word(CMD_REMOVE, '0, '0);
      send_word(CMD_REMOVE, 31'h0BAD_0BAD, PAY_MAX);
      send_word(CMD_DUMP, KEY_MAX, PAY_MAX);
   endtask

   task automatic test_random_traffic();
      logic [KEY_W-1:0] key_pool [8];
      logic [KEY_W-1:0] k;
      int               roll;
      bit               grow;
      grow = 1'b0;
      for (int i = 0; i < 8; i++)
         key_pool[i] = KEY_W'($urandom());
      for (int n = 0; n < 194; n++) begin
         // alternate filling and draining so both full and empty lists recur
         if (n % 30 == 0) begin
            grow = ~grow;
            quiet_mode = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 2) == 0)
            k = KEY_W'($urandom());
         else
            k = key_pool[$urandom_range(0, 7)];
         if (roll < 12) begin
            send_word(CMD_DUMP, KEY_W'($urandom()), $urandom());
         end else if (roll < 14) begin
            send_word(CMD_UNUSED, KEY_W'($urandom()), $urandom());
         end else if (roll < (grow ? 72 : 35)) begin
            send_word(CMD_APPEND, k, $urandom());
         end else begin
            if (list_count > 0 && $urandom_range(0, 3) != 0)
               k = list_keys[$urandom_range(0, list_count - 1)];
            send_word(CMD_REMOVE, k, $urandom());
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      list_count = 0;
      mismatch_count = 0;
      quiet_mode = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_APPEND;
      req_key <= '0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_fill_and_full();
      test_remove_cases();
      test_random_traffic();

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/oqrk_pkg.sv
rtl/oqrk_store.sv
rtl/ordered_queue_remove_by_key.sv
test/tb_ordered_queue_remove_by_key.sv
